/* sv/wsd_pkg.sv */
// wsd_pkg: types and constants shared by the websocket deframer modules
// no dependencies; compiled first
package wsd_pkg;

	// result error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_LEN64  = 2'd1;
	localparam logic [1:0] ERR_OPCODE = 2'd2;

	// header field masks and length escape codes
	localparam logic [7:0] HDR_TOP_BIT  = 8'h80;
	localparam logic [7:0] HDR_LEN_MASK = 8'h7F;
	localparam logic [7:0] HDR_OPC_MASK = 8'h0F;
	localparam logic [6:0] LEN_EXT16    = 7'd126;
	localparam logic [6:0] LEN_EXT64    = 7'd127;

	// supported opcodes
	localparam logic [3:0] OPC_CONT   = 4'd0;
	localparam logic [3:0] OPC_TEXT   = 4'd1;
	localparam logic [3:0] OPC_BINARY = 4'd2;
	localparam logic [3:0] OPC_PING   = 4'd9;
	localparam logic [3:0] OPC_PONG   = 4'd10;

	// one queued result: raw byte and key byte are combined in the back part
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] key;
		logic       payload_valid;
		logic       frame_end;
		logic       fin_flag;
		logic [3:0] frame_opcode;
		logic [1:0] error_code;
	} wsd_res_t;

endpackage

/* sv/wsd_if.sv */
// wsd_if: valid/ready channel interfaces for received bytes and results
// no dependencies; compiled after wsd_pkg
interface wsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       payload_valid;
	logic       frame_end;
	logic       fin_flag;
	logic [3:0] frame_opcode;
	logic [1:0] error_code;

	modport source (output valid, output payload_byte, output payload_valid,
		output frame_end, output fin_flag, output frame_opcode,
		output error_code, input ready);
	modport sink   (input valid, input payload_byte, input payload_valid,
		input frame_end, input fin_flag, input frame_opcode,
		input error_code, output ready);
endinterface

/* sv/websocket_frame_deframer_top.sv */
// websocket_frame_deframer_top: byte-stream websocket frame deframer
// depends on wsd_pkg, wsd_if, wsd_front, wsd_fifo, wsd_back
//
//  channel  dir  transaction
//  rx       in   one received byte (rx_byte)
//  res      out  one result: payload_byte, payload_valid, frame_end,
//                fin_flag, frame_opcode, error_code
//
// one byte is taken every cycle while the queue is not full; each result is
// written to a queue entry at the accepting edge, then moves to the result register
// arst_n clears parser phase, queue pointers and the result valid
// rx stalls only when the queue is full; while res is stalled the result
// register holds its transaction and the queue fills behind it
module websocket_frame_deframer_top
	import wsd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2   // 2 or more entries
)(
	input  logic      clk,
	input  logic      arst_n,
	wsd_in_if.sink    rx,
	wsd_out_if.source res
);

	logic     q_push, q_full, q_pop, q_empty;
	wsd_res_t q_wdata, q_rdata;

	// header parsing and classification
	wsd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	// decoupling queue
	wsd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	// unmasking and result register
	wsd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.res     (res)
	);

endmodule

/* sv/wsd_front.sv */
// wsd_front: header parser; takes one byte per transaction and pushes results
// depends on wsd_pkg and wsd_in_if
module wsd_front
	import wsd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	wsd_in_if.sink        rx,
	input  logic          q_full,
	output logic          q_push,
	output wsd_res_t      q_data
);

	// parser phases
	localparam logic [2:0] PH_HDR0  = 3'd0;
	localparam logic [2:0] PH_HDR1  = 3'd1;
	localparam logic [2:0] PH_EXTHI = 3'd2;
	localparam logic [2:0] PH_EXTLO = 3'd3;
	localparam logic [2:0] PH_MASK  = 3'd4;
	localparam logic [2:0] PH_DATA  = 3'd5;

	logic [2:0]  phase_q, phase_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        fin_q, fin_d;
	logic        masked_q, masked_d;
	logic [15:0] left_q, left_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  sub_q, sub_d;

	logic        accept;
	logic        emit;
	wsd_res_t    res;
	logic [6:0]  len7;
	logic [3:0]  opc_in;
	logic [15:0] left_dec;
	logic [7:0]  key_byte;

	assign rx.ready = ~q_full;
	assign accept   = rx.valid & ~q_full;
	assign len7     = rx.rx_byte[6:0] & HDR_LEN_MASK[6:0];
	assign opc_in   = rx.rx_byte[3:0] & HDR_OPC_MASK[3:0];
	assign left_dec = left_q - 16'd1;

	// key byte for the current payload offset, first key byte in the top bits
	always_comb begin
		case (sub_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// next state and result of the accepted byte
	always_comb begin
		phase_d  = phase_q;
		opcode_d = opcode_q;
		fin_d    = fin_q;
		masked_d = masked_q;
		left_d   = left_q;
		key_d    = key_q;
		sub_d    = sub_q;
		emit     = 1'b0;
		res      = '0;
		case (phase_q)
			PH_HDR1: begin
				masked_d = |(rx.rx_byte & HDR_TOP_BIT);
				if (len7 == LEN_EXT64) begin
					phase_d        = PH_HDR0;
					emit           = 1'b1;
					res.frame_end  = 1'b1;
					res.error_code = ERR_LEN64;
				end else if (len7 == LEN_EXT16) begin
					phase_d = PH_EXTHI;
				end else begin
					left_d = {9'd0, len7};
					sub_d  = 2'd0;
					if (masked_d) begin
						phase_d = PH_MASK;
					end else if (len7 == 7'd0) begin
						phase_d       = PH_HDR0;
						emit          = 1'b1;
						res.frame_end = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_EXTHI: begin
				left_d  = {rx.rx_byte, 8'd0};
				phase_d = PH_EXTLO;
			end
			PH_EXTLO: begin
				left_d = {left_q[15:8], rx.rx_byte};
				sub_d  = 2'd0;
				if (masked_q) begin
					phase_d = PH_MASK;
				end else if (left_d == 16'd0) begin
					phase_d       = PH_HDR0;
					emit          = 1'b1;
					res.frame_end = 1'b1;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_MASK: begin
				key_d = {key_q[23:0], rx.rx_byte};
				if (sub_q == 2'd3) begin
					sub_d = 2'd0;
					if (left_q == 16'd0) begin
						phase_d       = PH_HDR0;
						emit          = 1'b1;
						res.frame_end = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end else begin
					sub_d = sub_q + 2'd1;
				end
			end
			PH_DATA: begin
				sub_d             = sub_q + 2'd1;
				left_d            = left_dec;
				emit              = 1'b1;
				res.data          = rx.rx_byte;
				res.key           = masked_q ? key_byte : 8'd0;
				res.payload_valid = 1'b1;
				res.frame_end     = (left_dec == 16'd0);
				if (left_dec == 16'd0) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				fin_d    = |(rx.rx_byte & HDR_TOP_BIT);
				opcode_d = opc_in;
				if (opc_in == OPC_CONT || opc_in == OPC_TEXT || opc_in == OPC_BINARY ||
					opc_in == OPC_PING || opc_in == OPC_PONG) begin
					phase_d = PH_HDR1;
				end else begin
					phase_d        = PH_HDR0;
					emit           = 1'b1;
					res.frame_end  = 1'b1;
					res.error_code = ERR_OPCODE;
				end
			end
		endcase
		res.fin_flag     = fin_d;
		res.frame_opcode = opcode_d;
	end

	assign q_push = accept & emit;
	assign q_data = res;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			opcode_q <= '0;
			fin_q    <= 1'b0;
			masked_q <= 1'b0;
			left_q   <= '0;
			key_q    <= '0;
			sub_q    <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			opcode_q <= opcode_d;
			fin_q    <= fin_d;
			masked_q <= masked_d;
			left_q   <= left_d;
			key_q    <= key_d;
			sub_q    <= sub_d;
		end
	end

endmodule

/* sv/wsd_fifo.sv */
// wsd_fifo: short result queue between the parser and the output stage
// depends on wsd_pkg
module wsd_fifo
	import wsd_pkg::*;
#(
	parameter int DEPTH = 2
)(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  wsd_res_t push_data,
	output logic     full,
	input  logic     pop,
	output wsd_res_t pop_data,
	output logic     empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULLC = CW'(DEPTH);

	wsd_res_t      mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full     = (cnt_q == FULLC);
	assign empty    = (cnt_q == '0);
	assign do_push  = push & ~full;
	assign do_pop   = pop & ~empty;
	assign pop_data = mem_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

/* sv/wsd_back.sv */
// wsd_back: output stage; unmasks queued payload bytes into the result register
// depends on wsd_pkg and wsd_out_if
module wsd_back
	import wsd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  wsd_res_t  q_data,
	output logic      q_pop,
	wsd_out_if.source res
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       pvalid_q;
	logic       end_q;
	logic       fin_q;
	logic [3:0] opcode_q;
	logic [1:0] err_q;

	// take the next entry whenever the result register is free or draining
	assign q_pop = ~q_empty & (~valid_q | res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || res.ready) begin
			valid_q <= ~q_empty;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			byte_q   <= q_data.data ^ q_data.key;
			pvalid_q <= q_data.payload_valid;
			end_q    <= q_data.frame_end;
			fin_q    <= q_data.fin_flag;
			opcode_q <= q_data.frame_opcode;
			err_q    <= q_data.error_code;
		end
	end

	assign res.valid         = valid_q;
	assign res.payload_byte  = byte_q;
	assign res.payload_valid = pvalid_q;
	assign res.frame_end     = end_q;
	assign res.fin_flag      = fin_q;
	assign res.frame_opcode  = opcode_q;
	assign res.error_code    = err_q;

endmodule
